// File: design/hbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_pkg
// shared types and constants of the haplotype block parser
// ----------------------------------------------------------------------------
package hbp_pkg;

  // parse phase, also the kind code of the result it produces
  typedef enum logic [3:0] {
    PH_MARKER_COUNT = 4'd0,
    PH_UNIQUE_COUNT = 4'd1,
    PH_MAPPING      = 4'd2,
    PH_POSITION     = 4'd3,
    PH_ID_LEN       = 4'd4,
    PH_ID_BYTE      = 4'd5,
    PH_REF_LEN      = 4'd6,
    PH_REF_BYTE     = 4'd7,
    PH_ALT_LEN      = 4'd8,
    PH_ALT_BYTE     = 4'd9,
    PH_MATRIX       = 4'd10
  } hbp_phase_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PLOIDY       = 1'b1;

  // allele codes of a matrix byte
  localparam logic [1:0] ALLELE_REF     = 2'd0;
  localparam logic [1:0] ALLELE_ALT     = 2'd1;
  localparam logic [1:0] ALLELE_MISSING = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  // unique count limits for 1 and 2 byte mapping entries
  localparam logic [31:0] MAP_W1_MAX = 32'h0000_0100;
  localparam logic [31:0] MAP_W2_MAX = 32'h0001_0000;

  // bytes per fixed field
  localparam logic [3:0] HEADER_BYTES = 4'd4;
  localparam logic [3:0] POS_BYTES    = 4'd8;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } hbp_cfg_wr_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [31:0] marker_index;
    logic [31:0] element_index;
    logic [1:0]  allele;
    logic        block_last;
  } hbp_result_t;

endpackage

// File: design/hbp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_cfg
// sample count and ploidy registers with registered haplotype count
// ----------------------------------------------------------------------------
module hbp_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hbp_pkg::hbp_cfg_wr_t wr_i,
  output logic [31:0]         haps_o
);

  logic [23:0] sample_q, sample_d;
  logic [7:0]  ploidy_q, ploidy_d;
  logic [31:0] haps_q, haps_d;

  always_comb begin
    sample_d = sample_q;
    ploidy_d = ploidy_q;
    haps_d   = haps_q;
    if (wr_i.valid) begin
      case (wr_i.index)
        hbp_pkg::CFG_SAMPLE_COUNT: begin
          sample_d = wr_i.data[23:0];
          haps_d   = {8'd0, wr_i.data[23:0]} * {24'd0, ploidy_q};
        end
        hbp_pkg::CFG_PLOIDY: begin
          ploidy_d = wr_i.data[7:0];
          haps_d   = {8'd0, sample_q} * {24'd0, wr_i.data[7:0]};
        end
        default: begin
          sample_d = sample_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= 24'd0;
      ploidy_q <= 8'd2;
      haps_q   <= 32'd0;
    end else begin
      sample_q <= sample_d;
      ploidy_q <= ploidy_d;
      haps_q   <= haps_d;
    end
  end

  assign haps_o = haps_q;

endmodule

// File: design/hbp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_parser
// parse state and one-byte step logic of the block stream
// ----------------------------------------------------------------------------
module hbp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic [31:0]          haps_i,
  output logic                 emit_o,
  output hbp_pkg::hbp_result_t result_o
);

  hbp_pkg::hbp_phase_e phase_q, phase_d;
  logic [2:0]  bif_q, bif_d;
  logic [63:0] asm_q, asm_d;
  logic [31:0] mtot_q, mtot_d;
  logic [31:0] utot_q, utot_d;
  logic [2:0]  mapw_q, mapw_d;
  logic [31:0] mcnt_q, mcnt_d;
  logic [31:0] ecnt_q, ecnt_d;
  logic [7:0]  srem_q, srem_d;

  logic [63:0] asm_next;
  logic [3:0]  need;
  logic        partial;
  logic [31:0] ecnt_inc;
  logic [31:0] mcnt_inc;
  logic [7:0]  srem_dec;
  logic        enter_mark;
  logic        enter_mat;
  logic        end_mark;
  logic        restart;

  assign asm_next = {asm_q[55:0], byte_i};
  assign ecnt_inc = ecnt_q + 32'd1;
  assign mcnt_inc = mcnt_q + 32'd1;
  assign srem_dec = srem_q - 8'd1;

  always_comb begin
    case (phase_q)
      hbp_pkg::PH_MARKER_COUNT, hbp_pkg::PH_UNIQUE_COUNT: need = hbp_pkg::HEADER_BYTES;
      hbp_pkg::PH_MAPPING:  need = {1'b0, mapw_q};
      hbp_pkg::PH_POSITION: need = hbp_pkg::POS_BYTES;
      default:              need = 4'd0;
    endcase
    partial = (need != 4'd0) && (({1'b0, bif_q} + 4'd1) < need);
  end

  always_comb begin
    phase_d = phase_q;
    bif_d   = bif_q;
    asm_d   = asm_q;
    mtot_d  = mtot_q;
    utot_d  = utot_q;
    mapw_d  = mapw_q;
    mcnt_d  = mcnt_q;
    ecnt_d  = ecnt_q;
    srem_d  = srem_q;

    emit_o                 = 1'b0;
    result_o.kind          = phase_q;
    result_o.value         = {56'd0, byte_i};
    result_o.marker_index  = mcnt_q;
    result_o.element_index = 32'd0;
    result_o.allele        = hbp_pkg::ALLELE_REF;
    result_o.block_last    = 1'b0;

    enter_mark = 1'b0;
    enter_mat  = 1'b0;
    end_mark   = 1'b0;
    restart    = 1'b0;

    if (step_i) begin
      if (partial) begin
        // field still collecting bytes
        asm_d = asm_next;
        bif_d = bif_q + 3'd1;
      end else begin
        if (need != 4'd0) begin
          bif_d          = 3'd0;
          asm_d          = 64'd0;
          result_o.value = asm_next;
        end
        emit_o = 1'b1;
        case (phase_q)
          hbp_pkg::PH_MARKER_COUNT: begin
            result_o.marker_index = 32'd0;
            mtot_d  = asm_next[31:0];
            phase_d = hbp_pkg::PH_UNIQUE_COUNT;
          end
          hbp_pkg::PH_UNIQUE_COUNT: begin
            result_o.marker_index = 32'd0;
            utot_d = asm_next[31:0];
            if (asm_next[31:0] <= hbp_pkg::MAP_W1_MAX) begin
              mapw_d = 3'd1;
            end else if (asm_next[31:0] <= hbp_pkg::MAP_W2_MAX) begin
              mapw_d = 3'd2;
            end else begin
              mapw_d = 3'd4;
            end
            ecnt_d = 32'd0;
            if (haps_i != 32'd0) begin
              phase_d = hbp_pkg::PH_MAPPING;
            end else begin
              enter_mark = 1'b1;
            end
          end
          hbp_pkg::PH_MAPPING: begin
            result_o.marker_index  = 32'd0;
            result_o.element_index = ecnt_q;
            ecnt_d = ecnt_inc;
            if (ecnt_inc >= haps_i) begin
              enter_mark = 1'b1;
            end
          end
          hbp_pkg::PH_POSITION: begin
            phase_d = hbp_pkg::PH_ID_LEN;
          end
          hbp_pkg::PH_ID_LEN, hbp_pkg::PH_REF_LEN, hbp_pkg::PH_ALT_LEN: begin
            srem_d = byte_i;
            ecnt_d = 32'd0;
            if (byte_i != 8'd0) begin
              phase_d = hbp_pkg::hbp_phase_e'(phase_q + 4'd1);
            end else if (phase_q == hbp_pkg::PH_ALT_LEN) begin
              enter_mat = 1'b1;
            end else begin
              phase_d = hbp_pkg::hbp_phase_e'(phase_q + 4'd2);
            end
          end
          hbp_pkg::PH_ID_BYTE, hbp_pkg::PH_REF_BYTE, hbp_pkg::PH_ALT_BYTE: begin
            result_o.element_index = ecnt_q;
            ecnt_d = ecnt_inc;
            srem_d = srem_dec;
            if (srem_dec == 8'd0) begin
              if (phase_q == hbp_pkg::PH_ALT_BYTE) begin
                enter_mat = 1'b1;
              end else begin
                phase_d = hbp_pkg::hbp_phase_e'(phase_q + 4'd1);
              end
            end
          end
          hbp_pkg::PH_MATRIX: begin
            result_o.element_index = ecnt_q;
            if (byte_i == hbp_pkg::CHAR_ZERO) begin
              result_o.allele = hbp_pkg::ALLELE_REF;
            end else if (byte_i == hbp_pkg::CHAR_ONE) begin
              result_o.allele = hbp_pkg::ALLELE_ALT;
            end else begin
              result_o.allele = hbp_pkg::ALLELE_MISSING;
            end
            ecnt_d = ecnt_inc;
            if (ecnt_inc >= utot_q) begin
              end_mark = 1'b1;
            end
          end
          default: begin
            // unreachable phase: start over silently
            emit_o  = 1'b0;
            restart = 1'b1;
          end
        endcase
      end
    end

    // matrix entry, may close the marker at once
    if (enter_mat) begin
      ecnt_d = 32'd0;
      if (utot_q == 32'd0) begin
        end_mark = 1'b1;
      end else begin
        phase_d = hbp_pkg::PH_MATRIX;
      end
    end

    if (end_mark) begin
      if (mcnt_inc >= mtot_q) begin
        restart             = 1'b1;
        result_o.block_last = 1'b1;
      end else begin
        mcnt_d  = mcnt_inc;
        phase_d = hbp_pkg::PH_POSITION;
      end
    end

    if (enter_mark) begin
      mcnt_d = 32'd0;
      if (mtot_q == 32'd0) begin
        restart             = 1'b1;
        result_o.block_last = 1'b1;
      end else begin
        phase_d = hbp_pkg::PH_POSITION;
      end
    end

    if (restart) begin
      phase_d = hbp_pkg::PH_MARKER_COUNT;
      bif_d   = 3'd0;
      asm_d   = 64'd0;
      mcnt_d  = 32'd0;
      ecnt_d  = 32'd0;
      srem_d  = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hbp_pkg::PH_MARKER_COUNT;
      bif_q   <= 3'd0;
      asm_q   <= 64'd0;
      mtot_q  <= 32'd0;
      utot_q  <= 32'd0;
      mapw_q  <= 3'd1;
      mcnt_q  <= 32'd0;
      ecnt_q  <= 32'd0;
      srem_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      asm_q   <= asm_d;
      mtot_q  <= mtot_d;
      utot_q  <= utot_d;
      mapw_q  <= mapw_d;
      mcnt_q  <= mcnt_d;
      ecnt_q  <= ecnt_d;
      srem_q  <= srem_d;
    end
  end

endmodule

// File: design/haplotype_block_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haplotype_block_parser_unit
// byte-wide parser of a compressed haplotype block stream, one field per item
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                  payload
// -------  ---------  -------------------------  ---------------------------------
// in       input      in_valid_i / in_ready_o    data_byte_i
// out      output     out_valid_o / out_ready_i  kind, value, marker/element index,
//                                                allele, block_last
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one byte per clock sustained while the output is not stalled; an accepted byte
// waits in the input register until the parser step takes it, and a completed
// field goes on into the result register; a byte yields at most one result
// cfg writes always complete; the haplotype count product is registered at
// write time, so items may follow the write on the next cycle
// reset clears all parse state, ploidy to 2, sample count to 0
// output stall backs up through the input register; no item is dropped
//
module haplotype_block_parser_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input byte channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   kind_o,
  output logic [63:0]                  value_o,
  output logic [31:0]                  marker_index_o,
  output logic [31:0]                  element_index_o,
  output logic [1:0]                   allele_o,
  output logic                         block_last_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hbp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hbp_pkg::CfgDataW-1:0] cfg_data_i
);

  hbp_pkg::hbp_cfg_wr_t cfg_wr;
  logic [31:0]          haps;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       step;

  // result register
  logic                 out_valid_q, out_valid_d;
  hbp_pkg::hbp_result_t res_q, res_d;
  hbp_pkg::hbp_result_t step_res;
  logic                 step_emit;

  // config writes are never stalled
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  hbp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_wr),
    .haps_o (haps)
  );

  // the held byte moves on whenever the result slot is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      in_byte_d  = data_byte_i;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  hbp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .haps_i   (haps),
    .emit_o   (step_emit),
    .result_o (step_res)
  );

  // result register loads on emit, empties when taken
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (step && step_emit) begin
      out_valid_d = 1'b1;
      res_d       = step_res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    res_q     <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign value_o         = res_q.value;
  assign marker_index_o  = res_q.marker_index;
  assign element_index_o = res_q.element_index;
  assign allele_o        = res_q.allele;
  assign block_last_o    = res_q.block_last;

`ifndef ASSERT_OFF
  // a held byte is not lost or altered while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q))
    else $error("input byte lost during stall");

  // a block can only end on the unique count, mapping, alt length, last alt byte or matrix
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_last_o |->
      kind_o != 4'(hbp_pkg::PH_MARKER_COUNT) && kind_o != 4'(hbp_pkg::PH_POSITION) &&
      kind_o != 4'(hbp_pkg::PH_ID_BYTE) && kind_o != 4'(hbp_pkg::PH_REF_BYTE))
    else $error("block end flagged on impossible kind");

  // only matrix results carry an allele code
  a_allele_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && allele_o != hbp_pkg::ALLELE_REF |->
      kind_o == 4'(hbp_pkg::PH_MATRIX) && allele_o != 2'd3)
    else $error("allele on non-matrix result");

  // header and mapping results sit outside any marker
  a_header_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == 4'(hbp_pkg::PH_MARKER_COUNT) ||
      kind_o == 4'(hbp_pkg::PH_UNIQUE_COUNT) || kind_o == 4'(hbp_pkg::PH_MAPPING)) |->
      marker_index_o == 32'd0)
    else $error("header result with nonzero marker index");
`endif

endmodule

// File: verif/hbp_field_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_field_checker
// tracks the block parse state from the accepted bytes and config writes,
// predicts every emitted field and compares it with what the parser returns
// ----------------------------------------------------------------------------
module hbp_field_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [3:0]                   kind_i,
  input  logic [63:0]                  value_i,
  input  logic [31:0]                  marker_index_i,
  input  logic [31:0]                  element_index_i,
  input  logic [1:0]                   allele_i,
  input  logic                         block_last_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [hbp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hbp_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  // parse state
  hbp_pkg::hbp_phase_e ph;
  logic [2:0]  field_pos;
  logic [63:0] acc;
  logic [31:0] num_markers;
  logic [31:0] num_unique;
  logic [2:0]  map_bytes;
  logic [31:0] cur_marker;
  logic [31:0] cur_elem;
  logic [7:0]  str_left;
  // config copy
  logic [23:0] samples;
  logic [7:0]  ploid;

  hbp_pkg::hbp_result_t fields_due[$];

  function automatic void clear_parse();
    ph         = hbp_pkg::PH_MARKER_COUNT;
    field_pos  = '0;
    acc        = '0;
    cur_marker = '0;
    cur_elem   = '0;
    str_left   = '0;
  endfunction

  // returns 1 when the block ends with no markers
  function automatic bit enter_markers();
    cur_marker = '0;
    if (num_markers == 0) begin
      clear_parse();
      return 1'b1;
    end
    ph = hbp_pkg::PH_POSITION;
    return 1'b0;
  endfunction

  function automatic bit end_marker();
    cur_marker = cur_marker + 32'd1;
    if (cur_marker >= num_markers) begin
      clear_parse();
      return 1'b1;
    end
    ph = hbp_pkg::PH_POSITION;
    return 1'b0;
  endfunction

  function automatic bit enter_matrix();
    cur_elem = '0;
    if (num_unique == 0) return end_marker();
    ph = hbp_pkg::PH_MATRIX;
    return 1'b0;
  endfunction

  // one byte in, returns 1 with the field it completes
  function automatic bit parse_byte(input logic [7:0] b, output hbp_pkg::hbp_result_t r);
    logic [63:0] haps;
    logic [63:0] val;
    int          need;
    haps            = {40'b0, samples} * {56'b0, ploid};
    r               = '0;
    r.kind          = ph;
    r.marker_index  = cur_marker;
    val             = {56'b0, b};
    case (ph)
      hbp_pkg::PH_MARKER_COUNT, hbp_pkg::PH_UNIQUE_COUNT: need = int'(hbp_pkg::HEADER_BYTES);
      hbp_pkg::PH_MAPPING:  need = int'(map_bytes);
      hbp_pkg::PH_POSITION: need = int'(hbp_pkg::POS_BYTES);
      default:              need = 0;
    endcase
    if (need != 0) begin
      acc = {acc[55:0], b};
      if (int'(field_pos) + 1 < need) begin
        field_pos = field_pos + 3'd1;
        return 1'b0;
      end
      field_pos = '0;
      val       = acc;
      acc       = '0;
    end
    case (ph)
      hbp_pkg::PH_MARKER_COUNT: begin
        r.marker_index = '0;
        num_markers    = val[31:0];
        ph             = hbp_pkg::PH_UNIQUE_COUNT;
      end
      hbp_pkg::PH_UNIQUE_COUNT: begin
        r.marker_index = '0;
        num_unique     = val[31:0];
        if (num_unique <= hbp_pkg::MAP_W1_MAX) map_bytes = 3'd1;
        else if (num_unique <= hbp_pkg::MAP_W2_MAX) map_bytes = 3'd2;
        else map_bytes = 3'd4;
        cur_elem = '0;
        if (haps > 0) ph = hbp_pkg::PH_MAPPING;
        else r.block_last = enter_markers();
      end
      hbp_pkg::PH_MAPPING: begin
        r.marker_index  = '0;
        r.element_index = cur_elem;
        cur_elem        = cur_elem + 32'd1;
        // count may have shrunk under a config write, hence >=
        if ({32'b0, cur_elem} >= haps) r.block_last = enter_markers();
      end
      hbp_pkg::PH_POSITION: ph = hbp_pkg::PH_ID_LEN;
      hbp_pkg::PH_ID_LEN, hbp_pkg::PH_REF_LEN, hbp_pkg::PH_ALT_LEN: begin
        str_left = b;
        cur_elem = '0;
        if (b != 0) ph = hbp_pkg::hbp_phase_e'(ph + 4'd1);
        else if (ph == hbp_pkg::PH_ALT_LEN) r.block_last = enter_matrix();
        else ph = hbp_pkg::hbp_phase_e'(ph + 4'd2);
      end
      hbp_pkg::PH_ID_BYTE, hbp_pkg::PH_REF_BYTE, hbp_pkg::PH_ALT_BYTE: begin
        r.element_index = cur_elem;
        cur_elem        = cur_elem + 32'd1;
        str_left        = str_left - 8'd1;
        if (str_left == 0) begin
          if (ph == hbp_pkg::PH_ALT_BYTE) r.block_last = enter_matrix();
          else ph = hbp_pkg::hbp_phase_e'(ph + 4'd1);
        end
      end
      hbp_pkg::PH_MATRIX: begin
        r.element_index = cur_elem;
        r.allele = (b == hbp_pkg::CHAR_ZERO) ? hbp_pkg::ALLELE_REF :
                   (b == hbp_pkg::CHAR_ONE)  ? hbp_pkg::ALLELE_ALT :
                                               hbp_pkg::ALLELE_MISSING;
        cur_elem = cur_elem + 32'd1;
        if (cur_elem >= num_unique) r.block_last = end_marker();
      end
      default: begin
        clear_parse();
        return 1'b0;
      end
    endcase
    r.value = val;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    hbp_pkg::hbp_result_t seen;
    hbp_pkg::hbp_result_t due;
    hbp_pkg::hbp_result_t fresh;
    if (!rst_ni) begin
      clear_parse();
      samples      = '0;
      ploid        = 8'd2;
      num_markers  = '0;
      num_unique   = '0;
      map_bytes    = 3'd1;
      fields_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first: anything leaving now was predicted from an earlier accepted byte
      if (out_valid_i && out_ready_i) begin
        seen.kind          = kind_i;
        seen.value         = value_i;
        seen.marker_index  = marker_index_i;
        seen.element_index = element_index_i;
        seen.allele        = allele_i;
        seen.block_last    = block_last_i;
        if (fields_due.size() == 0) begin
          $error("unexpected result: kind %0d value %0h", kind_i, value_i);
          fail_count_o++;
        end else begin
          due = fields_due.pop_front();
          if (seen.kind != due.kind) begin
            $error("kind: expected %0d, got %0d", due.kind, seen.kind);
            fail_count_o++;
          end
          if (seen.value != due.value) begin
            $error("value: expected %0h, got %0h", due.value, seen.value);
            fail_count_o++;
          end
          if (seen.marker_index != due.marker_index) begin
            $error("marker_index: expected %0d, got %0d", due.marker_index,
                   seen.marker_index);
            fail_count_o++;
          end
          if (seen.element_index != due.element_index) begin
            $error("element_index: expected %0d, got %0d", due.element_index,
                   seen.element_index);
            fail_count_o++;
          end
          if (seen.allele != due.allele) begin
            $error("allele: expected %0d, got %0d", due.allele, seen.allele);
            fail_count_o++;
          end
          if (seen.block_last != due.block_last) begin
            $error("block_last: expected %0d, got %0d", due.block_last,
                   seen.block_last);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          hbp_pkg::CFG_SAMPLE_COUNT: samples = cfg_data_i;
          hbp_pkg::CFG_PLOIDY:       ploid   = cfg_data_i[7:0];
          default:                   ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_byte(data_byte_i, fresh)) fields_due.push_back(fresh);
      end
      pending_o = fields_due.size();
    end
  end

endmodule

// File: verif/tb_haplotype_block_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haplotype_block_parser_unit
// streams haplotype blocks byte by byte through the parser under random
// bursts, output stalls and config changes; a checker beside the dut predicts
// and compares every field, this top drives the traffic and calls the verdict
// ----------------------------------------------------------------------------
module tb_haplotype_block_parser_unit;

  // run bounds
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned LongHold     = 300;   // receiver hold-off, in cycles
  localparam int unsigned RandomItems  = 1250;
  localparam int unsigned PhaseItems   = 150;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_THIRD,
    RX_TRICKLE
  } rx_mode_e;

  logic                         clk;
  logic                         rst_n;
  // byte channel
  logic                         in_valid;
  logic                         in_ready;
  logic [7:0]                   data_byte;
  // result channel
  logic                         out_valid;
  logic                         out_ready;
  logic [3:0]                   kind;
  logic [63:0]                  value;
  logic [31:0]                  marker_index;
  logic [31:0]                  element_index;
  logic [1:0]                   allele;
  logic                         block_last;
  // config channel
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [hbp_pkg::CfgIdxW-1:0]  cfg_index;
  logic [hbp_pkg::CfgDataW-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned sent_items;
  int unsigned burst_left;
  bit          gaps_on;
  bit          hold_req;
  // config as last written, needed to shape well-formed blocks
  logic [23:0] cur_samples;
  logic [7:0]  cur_ploidy;

  haplotype_block_parser_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .value_o         (value),
    .marker_index_o  (marker_index),
    .element_index_o (element_index),
    .allele_o        (allele),
    .block_last_o    (block_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  hbp_field_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .data_byte_i     (data_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .kind_i          (kind),
    .value_i         (value),
    .marker_index_i  (marker_index),
    .element_index_i (element_index),
    .allele_i        (allele),
    .block_last_i    (block_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: rotates through stall patterns, and on request holds off
  // for a long stretch so the parser backs up into its input
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned left;
    out_ready = 1'b0;
    mode      = RX_OPEN;
    left      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (LongHold) @(negedge clk);
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        RX_OPEN:  out_ready = 1'b1;
        RX_COIN:  out_ready = 1'($urandom_range(0, 1));
        RX_THIRD: out_ready = (left % 3 == 0);
        default:  out_ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // offer one byte, called at a falling edge, returns at a falling edge;
  // valid stays up across back-to-back items within a burst
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  = 1'b1;
    data_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // big-endian field of nbytes
  task automatic put_be(input logic [63:0] v, input int unsigned nbytes);
    for (int i = int'(nbytes) - 1; i >= 0; i--) push_byte(v[8*i +: 8]);
  endtask

  // stop offering and wait out every expected field, then the pipeline
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [hbp_pkg::CfgIdxW-1:0] idx,
                           input logic [hbp_pkg::CfgDataW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // both registers in random order; junk above the ploidy byte
  task automatic set_config(input logic [23:0] samples, input logic [7:0] ploidy);
    if ($urandom_range(0, 1)) begin
      write_reg(hbp_pkg::CFG_SAMPLE_COUNT, samples);
      write_reg(hbp_pkg::CFG_PLOIDY, {16'($urandom), ploidy});
    end else begin
      write_reg(hbp_pkg::CFG_PLOIDY, {16'($urandom), ploidy});
      write_reg(hbp_pkg::CFG_SAMPLE_COUNT, samples);
    end
    cur_samples = samples;
    cur_ploidy  = ploidy;
  endtask

  // one well-formed block; a negative string length means random per marker
  task automatic send_block(input logic [31:0] markers, input logic [31:0] uniq,
                            input int id_len, input int ref_len, input int alt_len);
    logic [63:0] haps;
    int unsigned width;
    int          lens[3];
    int          n;
    haps  = {40'b0, cur_samples} * {56'b0, cur_ploidy};
    width = (uniq <= hbp_pkg::MAP_W1_MAX) ? 1 : (uniq <= hbp_pkg::MAP_W2_MAX) ? 2 : 4;
    put_be({32'b0, markers}, 4);
    put_be({32'b0, uniq}, 4);
    for (longint unsigned h = 0; h < haps; h++) put_be({32'b0, $urandom}, width);
    for (int unsigned m = 0; m < markers; m++) begin
      // position, with all-zero and all-one values now and then
      case ($urandom_range(0, 4))
        0:       put_be('0, 8);
        1:       put_be('1, 8);
        default: put_be({$urandom, $urandom}, 8);
      endcase
      // id, ref, alt: rarely the longest length a byte allows
      lens = '{id_len, ref_len, alt_len};
      foreach (lens[s]) begin
        n = lens[s];
        if (n < 0) n = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 3);
        push_byte(8'(n));
        repeat (n) push_byte(8'($urandom));
      end
      // matrix row, mostly allele digits with some missing codes
      for (int unsigned u = 0; u < uniq; u++)
        push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom) :
                  ($urandom_range(0, 1) ? hbp_pkg::CHAR_ONE : hbp_pkg::CHAR_ZERO));
    end
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned phase_end;
    int unsigned pick;
    logic [31:0] mk;
    logic [31:0] uq;
    logic [63:0] haps;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    data_byte   = '0;
    cfg_valid   = 1'b0;
    cfg_index   = hbp_pkg::CFG_SAMPLE_COUNT;
    cfg_data    = '0;
    sent_items  = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    hold_req    = 1'b0;
    cur_samples = '0;
    cur_ploidy  = 8'd2;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // reset config has no haplotypes: block closes on the unique count
    send_block(32'd0, 32'd0, 0, 0, 0);
    wait_drained();
    set_config(24'd1, 8'd1);
    // empty ref and alt, matrix closes the block
    send_block(32'd1, 32'd2, 1, 0, 0);
    // no unique haplotypes: block closes on the alt length
    send_block(32'd1, 32'd0, 0, 1, 0);
    // ... or on the last alt byte
    send_block(32'd1, 32'd0, 0, 0, 2);
    // no markers: block closes on the last mapping entry
    send_block(32'd0, 32'd5, -1, -1, -1);
    // haplotype count shrinks mid-mapping: next entry overshoots and closes
    wait_drained();
    set_config(24'd2, 8'd2);
    put_be(64'd0, 4);
    put_be(64'd3, 4);
    push_byte(8'hFF);
    push_byte(8'h00);
    wait_drained();
    set_config(24'd1, 8'd1);
    push_byte(8'h5A);

    // --- random blocks, config changed between phases ---
    base = sent_items;
    for (int p = 0; sent_items - base < RandomItems; p++) begin
      wait_drained();
      case (p)
        0:       set_config(24'd1, 8'd1);
        1:       set_config(24'd3, 8'd2);
        2:       set_config(24'hFF_FFFF, 8'd0);
        3:       set_config(24'd1, 8'd255);
        4:       set_config(24'd0, 8'd255);
        5:       set_config(24'd2, 8'd3);
        default: set_config(24'($urandom_range(0, 4)), 8'($urandom_range(0, 3)));
      endcase
      gaps_on = (p % 3 != 1);
      // long receiver hold-off while bytes keep coming
      if (p == 1 || p == 5) hold_req = 1'b1;
      phase_end = sent_items + PhaseItems;
      while (sent_items < phase_end) begin
        haps = {40'b0, cur_samples} * {56'b0, cur_ploidy};
        mk   = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
        pick = $urandom_range(0, 19);
        // mapping width edges; wide unique counts only without markers
        if (pick == 0) uq = '0;
        else if (pick == 1 && mk <= 1) uq = hbp_pkg::MAP_W1_MAX;
        else if (pick == 2 && mk <= 1) uq = hbp_pkg::MAP_W1_MAX + 32'd1;
        else if (pick == 3 && mk == 0 && haps <= 16) begin
          case ($urandom_range(0, 3))
            0:       uq = hbp_pkg::MAP_W2_MAX;
            1:       uq = hbp_pkg::MAP_W2_MAX + 32'd1;
            2:       uq = '1;
            default: uq = $urandom;
          endcase
        end else uq = 32'($urandom_range(1, 6));
        send_block(mk, uq, -1, -1, -1);
      end
    end

    // --- tail: largest config, endless block header, then raw noise ---
    wait_drained();
    gaps_on = 1'b1;
    set_config(24'hFF_FFFF, 8'hFF);
    put_be('1, 4);
    put_be({32'b0, $urandom}, 4);
    repeat (48) push_byte(8'($urandom));
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
